// ===== design/frpq_pkg.sv =====
// ----------------------------------------------------------------------------
// frpq_pkg
// Types and constants shared by the framed packet receive queue modules.
// ----------------------------------------------------------------------------
package frpq_pkg;

   localparam logic [5:0] PAYLOAD_OFFSET = 6'd13;
   localparam logic [5:0] MIN_FRAME      = 6'd14;
   localparam logic [5:0] MAX_FRAME      = 6'd54;
   localparam logic [5:0] COUNT_MAX      = 6'd63;
   localparam logic [5:0] MAGIC_BYTES    = 6'd4;
   localparam logic [5:0] LENGTH_POS     = 6'd7;

   // frame magic, index 0 is the first byte: M E T T
   localparam logic [3:0][7:0] MAGIC = {8'h54, 8'h54, 8'h45, 8'h4D};

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [4:0] payload_len;
      logic       last;
      logic       empty_res;
      logic [3:0] packets_waiting;
   } rsp_type;

   // one pop order, front to back
   typedef struct packed {
      logic       is_empty;
      logic [5:0] slot;
      logic [3:0] waiting;
   } desc_type;

   // store writes, front to back
   typedef struct packed {
      logic       byte_en;
      logic [5:0] byte_slot;
      logic [5:0] byte_off;
      logic [7:0] byte_data;
      logic       len_en;
      logic [5:0] len_slot;
      logic [5:0] len_val;
   } commit_type;

endpackage

// ===== design/framed_packet_receive_queue.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receive_queue
// Checks received frames, keeps good payloads in a drop-oldest packet ring
// and streams the oldest packet out on a pop command.
// ----------------------------------------------------------------------------
// Frame byte: one cycle per beat while busy is low. A pop with an idle back end
// passes the queue, the back end's IDLE and CHECK states and the registered
// store read, then streams one byte per cycle (set by the one read port of the
// payload store); a pop with nothing to stream gives one beat from CHECK.
// Up to two pops queue between front and back; busy rises while the queue is
// full or the slot being filled is still queued or streaming.
// Reset is synchronous: ring pointers and frame state clear at once; stores
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module framed_packet_receive_queue #(
   parameter int SLOTS   = 16,
   parameter int MAX_LEN = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  frpq_pkg::req_type  req_data,
   output logic               rsp_valid,
   output frpq_pkg::rsp_type  rsp_data
);
   import frpq_pkg::*;

   logic       desc_push, q_full, q_hit, b_hit, q_valid, q_pop;
   desc_type   desc_data, q_head;
   commit_type commit;
   logic [5:0] probe_slot;

   frpq_front #(
      .SLOTS   (SLOTS),
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .q_full     (q_full),
      .q_hit      (q_hit),
      .b_hit      (b_hit),
      .busy       (busy),
      .desc_push  (desc_push),
      .desc_data  (desc_data),
      .commit     (commit),
      .probe_slot (probe_slot)
   );

   frpq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_data  (desc_data),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_valid),
      .full       (q_full),
      .probe_slot (probe_slot),
      .hit        (q_hit)
   );

   frpq_back #(
      .SLOTS   (SLOTS),
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .q_head     (q_head),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .probe_slot (probe_slot),
      .b_hit      (b_hit),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/frpq_front.sv =====
// ----------------------------------------------------------------------------
// frpq_front
// Accepts beats, checks frames, fills the payload store and issues pop orders.
// ----------------------------------------------------------------------------
module frpq_front #(
   parameter int SLOTS   = 16,
   parameter int MAX_LEN = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  frpq_pkg::req_type     req_data,
   input  logic                  q_full,
   input  logic                  q_hit,
   input  logic                  b_hit,
   output logic                  busy,
   output logic                  desc_push,
   output frpq_pkg::desc_type    desc_data,
   output frpq_pkg::commit_type  commit,
   output logic [5:0]            probe_slot
);
   import frpq_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam logic [SW:0] SLOT_CNT = (SW+1)'(SLOTS);

   logic [SW-1:0] read_ff, read_in, write_ff, write_in;
   logic [5:0]    count_ff, count_in;
   logic          hdr_ff, hdr_in;
   logic [7:0]    decl_ff, decl_in;

   logic          accept;
   logic [5:0]    pos, cnt_next;
   logic          hdr_next, good, in_payload, ring_empty;
   logic [7:0]    decl_next;
   logic [SW-1:0] read_next, write_next;
   logic [SW:0]   wait_full;

   function automatic logic [SW-1:0] adv(input logic [SW-1:0] s);
      return (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   assign busy       = q_full | q_hit | b_hit;
   assign accept     = start & ~busy;
   assign probe_slot = 6'(write_ff);

   always_comb begin
      pos      = count_ff;
      hdr_next = hdr_ff;
      if (pos < MAGIC_BYTES && req_data.frame_byte != MAGIC[pos[1:0]]) begin
         hdr_next = 1'b0;
      end
      decl_next  = (pos == LENGTH_POS) ? req_data.frame_byte : decl_ff;
      cnt_next   = (pos < COUNT_MAX) ? pos + 6'd1 : COUNT_MAX;
      good       = cnt_next >= MIN_FRAME && cnt_next <= MAX_FRAME && hdr_next &&
                   decl_next < 8'(MAX_LEN) &&
                   (9'(PAYLOAD_OFFSET) + {1'b0, decl_next}) <= {3'b000, cnt_next};
      in_payload = pos >= PAYLOAD_OFFSET && (pos - PAYLOAD_OFFSET) < 6'(MAX_LEN);
      read_next  = adv(read_ff);
      write_next = adv(write_ff);
      ring_empty = read_ff == write_ff;
      if (write_ff >= read_next) begin
         wait_full = {1'b0, write_ff} - {1'b0, read_next};
      end else begin
         wait_full = {1'b0, write_ff} + SLOT_CNT - {1'b0, read_next};
      end

      read_in   = read_ff;
      write_in  = write_ff;
      count_in  = count_ff;
      hdr_in    = hdr_ff;
      decl_in   = decl_ff;
      commit    = '0;
      desc_push = 1'b0;
      desc_data = '0;

      if (accept && req_data.cmd == CMD_BYTE) begin
         count_in         = cnt_next;
         hdr_in           = hdr_next;
         decl_in          = decl_next;
         commit.byte_en   = in_payload;
         commit.byte_slot = 6'(write_ff);
         commit.byte_off  = pos - PAYLOAD_OFFSET;
         commit.byte_data = req_data.frame_byte;
         if (req_data.frame_end) begin
            if (good) begin
               commit.len_en   = 1'b1;
               commit.len_slot = 6'(write_ff);
               commit.len_val  = 6'(decl_next);
               write_in        = write_next;
               if (read_ff == write_next) begin
                  read_in = read_next;
               end
            end
            count_in = '0;
            hdr_in   = 1'b1;
            decl_in  = '0;
         end
      end else if (accept) begin
         desc_push = 1'b1;
         if (ring_empty) begin
            desc_data.is_empty = 1'b1;
         end else begin
            desc_data.slot    = 6'(read_ff);
            desc_data.waiting = 4'(wait_full);
            read_in           = read_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff  <= '0;
         write_ff <= '0;
         count_ff <= '0;
         hdr_ff   <= 1'b1;
         decl_ff  <= '0;
      end else begin
         read_ff  <= read_in;
         write_ff <= write_in;
         count_ff <= count_in;
         hdr_ff   <= hdr_in;
         decl_ff  <= decl_in;
      end
   end

   a_commit_leaves_ring_nonempty: assert property (@(posedge clock) disable iff (reset)
      commit.len_en |=> read_ff != write_ff)
      else $error("ring empty after commit");

endmodule

// ===== design/frpq_queue.sv =====
// ----------------------------------------------------------------------------
// frpq_queue
// Short queue of pop orders between front and back, with a slot lookup.
// ----------------------------------------------------------------------------
module frpq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  frpq_pkg::desc_type  push_data,
   input  logic                pop,
   output frpq_pkg::desc_type  head,
   output logic                head_valid,
   output logic                full,
   input  logic [5:0]          probe_slot,
   output logic                hit
);
   import frpq_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);

   desc_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] vld_ff;
   logic [QW-1:0]   wr_ptr_ff, rd_ptr_ff;

   function automatic logic [QW-1:0] adv(input logic [QW-1:0] p);
      return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = vld_ff[rd_ptr_ff];
   assign full       = vld_ff[wr_ptr_ff];

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (vld_ff[i] && !entry_ff[i].is_empty && entry_ff[i].slot == probe_slot) begin
            hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            vld_ff[wr_ptr_ff] <= 1'b1;
            wr_ptr_ff         <= adv(wr_ptr_ff);
         end
         if (pop) begin
            vld_ff[rd_ptr_ff] <= 1'b0;
            rd_ptr_ff         <= adv(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

// ===== design/frpq_back.sv =====
// ----------------------------------------------------------------------------
// frpq_back
// Holds the payload and length stores and streams popped packets as beats.
// ----------------------------------------------------------------------------
module frpq_back #(
   parameter int SLOTS   = 16,
   parameter int MAX_LEN = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  frpq_pkg::commit_type  commit,
   input  frpq_pkg::desc_type    q_head,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic [5:0]            probe_slot,
   output logic                  b_hit,
   output logic                  rsp_valid,
   output frpq_pkg::rsp_type     rsp_data
);
   import frpq_pkg::*;

   localparam int SW    = $clog2(SLOTS);
   localparam int LW    = $clog2(MAX_LEN);
   localparam int DEPTH = SLOTS * MAX_LEN;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [1:0] {
      IDLE,
      CHECK,
      STREAM
   } state_type;

   logic [7:0]    store_ff [DEPTH];
   logic [LW-1:0] slen_ff [SLOTS];

   state_type     state_ff;
   desc_type      cur_ff;
   logic [LW-1:0] idx_ff, len_ff, len_rd_ff;
   logic [7:0]    byte_rd_ff;
   logic          out_valid_ff, out_last_ff, out_empty_ff;
   logic [4:0]    out_len_ff;
   logic [3:0]    out_wait_ff;

   logic [AW-1:0] wr_addr, rd_addr;

   assign wr_addr = AW'(commit.byte_slot[SW-1:0]) * AW'(MAX_LEN) + AW'(commit.byte_off[LW-1:0]);
   assign rd_addr = AW'(cur_ff.slot[SW-1:0]) * AW'(MAX_LEN) + AW'(idx_ff);

   assign q_pop = state_ff == IDLE && q_valid;
   assign b_hit = state_ff != IDLE && !cur_ff.is_empty && cur_ff.slot == probe_slot;

   assign rsp_valid                = out_valid_ff;
   assign rsp_data.payload_byte    = out_empty_ff ? 8'd0 : byte_rd_ff;
   assign rsp_data.payload_len     = out_len_ff;
   assign rsp_data.last            = out_last_ff;
   assign rsp_data.empty_res       = out_empty_ff;
   assign rsp_data.packets_waiting = out_wait_ff;

   always_ff @(posedge clock) begin
      if (commit.byte_en) begin
         store_ff[wr_addr] <= commit.byte_data;
      end
      byte_rd_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (commit.len_en) begin
         slen_ff[commit.len_slot[SW-1:0]] <= commit.len_val[LW-1:0];
      end
      len_rd_ff <= slen_ff[q_head.slot[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (q_valid) begin
                  cur_ff   <= q_head;
                  idx_ff   <= '0;
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               if (cur_ff.is_empty || len_rd_ff == '0) begin
                  out_valid_ff <= 1'b1;
                  out_last_ff  <= 1'b1;
                  out_empty_ff <= 1'b1;
                  out_len_ff   <= '0;
                  out_wait_ff  <= cur_ff.waiting;
                  state_ff     <= IDLE;
               end else begin
                  len_ff   <= len_rd_ff;
                  state_ff <= STREAM;
               end
            end
            STREAM: begin
               out_valid_ff <= 1'b1;
               out_last_ff  <= idx_ff == len_ff - 1'b1;
               out_empty_ff <= 1'b0;
               out_len_ff   <= 5'(len_ff);
               out_wait_ff  <= cur_ff.waiting;
               idx_ff       <= idx_ff + 1'b1;
               if (idx_ff == len_ff - 1'b1) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   a_stream_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == STREAM |-> len_ff != '0)
      else $error("streaming a zero-length packet");

   a_stream_gives_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == STREAM |=> rsp_valid)
      else $error("stream cycle without result beat");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_empty_ff |-> out_last_ff)
      else $error("empty result without last mark");

endmodule
